// File: hdl/srer_pkg.sv
// Package for the shift register encoder reader: phase codes, the result record
// and the Gray-to-binary decode. No dependencies; the sequencer, output register, top and bench import it.
package srer_pkg;

  localparam int WordWidth = 15;
  localparam int AccWidth  = 16;
  localparam int CountWidth = 4;
  localparam logic [CountWidth-1:0] BitCountReset = 4'd10;

  typedef enum logic [2:0] {
    PH_PREPARE = 3'd0,
    PH_LOAD    = 3'd1,
    PH_HIGH    = 3'd2,
    PH_LOW     = 3'd3,
    PH_LATCH   = 3'd4
  } phase_t;

  typedef struct packed {
    logic                 shift_load_n;
    logic                 serial_clock;
    logic                 clock_inhibit;
    logic                 word_valid;
    logic [WordWidth-1:0] gray_word;
    logic [WordWidth-1:0] binary_word;
  } result_t;

  // Decodes the low n bits of a Gray word; bits at and above n are ignored.
  // Each binary bit is the XOR of all Gray bits at or above it, built as a
  // suffix XOR in four doubling steps.
  function automatic logic [WordWidth-1:0] gray_to_binary(
    input logic [WordWidth-1:0]  g,
    input logic [CountWidth-1:0] n
  );
    logic [WordWidth-1:0] mask;
    logic [WordWidth-1:0] b;
    mask = WordWidth'((AccWidth'(1) << n) - AccWidth'(1));
    b = g & mask;
    b = b ^ (b >> 1);
    b = b ^ (b >> 2);
    b = b ^ (b >> 4);
    b = b ^ (b >> 8);
    return b;
  endfunction

endpackage

// File: hdl/srer_in_if.sv
// Input channel of the shift register encoder reader: one sampled serial bit.
// Depends on nothing.
interface srer_in_if;
  logic valid;
  logic ready;
  logic serial_in;

  modport source (output valid, output serial_in, input ready);
  modport sink (input valid, input serial_in, output ready);
endinterface

// File: hdl/srer_out_if.sv
// Output channel of the shift register encoder reader: pin levels and the words.
// Depends on nothing.
interface srer_out_if;
  logic        valid;
  logic        ready;
  logic        shift_load_n;
  logic        serial_clock;
  logic        clock_inhibit;
  logic        word_valid;
  logic [14:0] gray_word;
  logic [14:0] binary_word;

  modport source (
    output valid, output shift_load_n, output serial_clock, output clock_inhibit,
    output word_valid, output gray_word, output binary_word, input ready
  );
  modport sink (
    input valid, input shift_load_n, input serial_clock, input clock_inhibit,
    input word_valid, input gray_word, input binary_word, output ready
  );
endinterface

// File: hdl/srer_sequencer.sv
// Phase sequencer: holds the phase, bit index, accumulator, latched Gray word
// and the bit_count register, and forms one result per tick. Uses srer_pkg.
module srer_sequencer import srer_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CountWidth-1:0] cfg_data,
  input  logic                  step,
  input  logic                  serial_in,
  output result_t               result
);

  phase_t                phase, phase_next;
  logic [CountWidth-1:0] bits_taken, bits_taken_next;
  logic [AccWidth-1:0]   shift_acc, shift_acc_next;
  logic [WordWidth-1:0]  latched_gray, latched_gray_next;
  logic [CountWidth-1:0] bit_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PREPARE;
      bits_taken   <= '0;
      shift_acc    <= '0;
      latched_gray <= '0;
    end else if (step) begin
      phase        <= phase_next;
      bits_taken   <= bits_taken_next;
      shift_acc    <= shift_acc_next;
      latched_gray <= latched_gray_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= BitCountReset;
    end else if (cfg_write) begin
      bit_count <= cfg_data;
    end
  end

  always_comb begin
    phase_next        = phase;
    bits_taken_next   = bits_taken;
    shift_acc_next    = shift_acc;
    latched_gray_next = latched_gray;
    result.shift_load_n  = 1'b1;
    result.serial_clock  = 1'b0;
    result.clock_inhibit = 1'b0;
    result.word_valid    = 1'b0;
    unique case (phase)
      PH_LOAD: begin
        result.shift_load_n  = 1'b0;
        result.clock_inhibit = 1'b1;
        phase_next = PH_HIGH;
      end
      PH_HIGH: begin
        result.serial_clock = 1'b1;
        shift_acc_next = shift_acc + (AccWidth'(serial_in) << bits_taken);
        // The frame ends once the index has reached bit_count.
        if (bits_taken >= bit_count) begin
          phase_next = PH_LATCH;
        end else begin
          bits_taken_next = bits_taken + CountWidth'(1);
          phase_next = PH_LOW;
        end
      end
      PH_LOW: begin
        phase_next = PH_HIGH;
      end
      PH_LATCH: begin
        // The first bit of the frame is a duplicate and is dropped.
        latched_gray_next = shift_acc[AccWidth-1:1];
        result.word_valid = 1'b1;
        phase_next = PH_PREPARE;
      end
      default: begin
        // Prepare phase; unused codes behave the same way.
        bits_taken_next = '0;
        shift_acc_next  = '0;
        phase_next      = PH_LOAD;
      end
    endcase
    result.gray_word   = latched_gray_next;
    result.binary_word = gray_to_binary(latched_gray_next, bit_count);
  end

endmodule

// File: hdl/srer_out_reg.sv
// Result register between the sequencer and the output channel; it takes a new
// result in the same cycle that the held one transfers. Uses srer_pkg, srer_out_if.
module srer_out_reg import srer_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load_valid,
  output logic        load_ready,
  input  result_t     load_data,
  srer_out_if.source  out_ch
);

  logic    valid;
  result_t data;

  assign load_ready = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_valid && load_ready) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      data <= load_data;
    end
  end

  assign out_ch.valid         = valid;
  assign out_ch.shift_load_n  = data.shift_load_n;
  assign out_ch.serial_clock  = data.serial_clock;
  assign out_ch.clock_inhibit = data.clock_inhibit;
  assign out_ch.word_valid    = data.word_valid;
  assign out_ch.gray_word     = data.gray_word;
  assign out_ch.binary_word   = data.binary_word;

endmodule

// File: hdl/shift_register_encoder_reader_unit.sv
// Top level of the shift register encoder reader.
// Uses srer_pkg, srer_in_if, srer_out_if, srer_sequencer and srer_out_reg.
//
// Each transfer on in_ch is one tick of the pin sequencer and carries the
// level of the shift register's serial output; it is used only in the clock
// high phase. Each tick yields exactly one transfer on out_ch with the pin
// levels for shift_load_n, serial_clock and clock_inhibit, a word_valid flag,
// the last latched Gray word and its binary decode over bit_count bits.
// A frame of N = bit_count bits takes 2*N + 4 ticks: prepare, load, N+1
// clock high phases with N clock low phases between them, and latch.
// The result of a tick sits in the output register from the cycle after its
// input transfer. One tick is taken every cycle, set by the single result
// register: in_ch.ready stays high while out_ch is empty or its held result
// transfers in the same cycle. When the receiver stalls, the held result
// stays on out_ch and in_ch.ready drops, so the sequencer waits without
// losing a tick. The user must write bit_count via cfg_write and cfg_data
// only while the block is idle; the block does not enforce it. Synchronous
// reset returns to the prepare phase, clears the accumulator and the
// latched word, sets bit_count to 10 and empties the output register.
module shift_register_encoder_reader_unit import srer_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CountWidth-1:0] cfg_data,
  srer_in_if.sink               in_ch,
  srer_out_if.source            out_ch
);

  logic    load_ready;
  result_t result;

  assign in_ch.ready = load_ready;

  srer_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (in_ch.valid && load_ready),
    .serial_in (in_ch.serial_in),
    .result    (result)
  );

  srer_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_ch.valid),
    .load_ready (load_ready),
    .load_data  (result),
    .out_ch     (out_ch)
  );

endmodule

// File: hdl/srer_checker.sv
// Port-level checks for the shift register encoder reader, bound to the top
// level. Depends on shift_register_encoder_reader_unit for the bind.
module srer_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        shift_load_n,
  input logic        serial_clock,
  input logic        clock_inhibit,
  input logic        word_valid,
  input logic [14:0] gray_word
);

  // An empty output register must never hold off the input.
  a_ready_when_empty: assert property (@(posedge clk) !out_valid |-> in_ready)
    else $error("input not ready while output register is empty");

  // Reset empties the output register.
  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // The load phase drives inhibit high and the clock low; the latch tick is idle on the pins.
  a_pin_phases: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (shift_load_n != clock_inhibit) &&
                  !(serial_clock && (clock_inhibit || word_valid)) &&
                  !(word_valid && !shift_load_n))
    else $error("pin levels do not form a legal phase");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gray_word) && $stable(word_valid))
    else $error("stalled result changed");

endmodule

bind shift_register_encoder_reader_unit srer_checker u_srer_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .shift_load_n  (out_ch.shift_load_n),
  .serial_clock  (out_ch.serial_clock),
  .clock_inhibit (out_ch.clock_inhibit),
  .word_valid    (out_ch.word_valid),
  .gray_word     (out_ch.gray_word)
);

// File: tb/testbench.sv
// Self-checking bench for shift_register_encoder_reader_unit: drives sequencer ticks
// with bursty valid and a stalling receiver, and predicts every pin/word result.
// Depends on srer_pkg, srer_in_if, srer_out_if and the unit under test.
module testbench;
  import srer_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 200000;
  localparam int ItemsPerStep = 117;
  localparam int DrainCycles  = 4;

  typedef struct {
    logic    serial;
    bit      typed;
    result_t want;
  } dir_row_t;

  // Pin levels and words that can be read directly off a fresh frame with all ones.
  localparam result_t PrepIdle  = {4'b1000, 15'h000, 15'h000};
  localparam result_t LoadPins  = {4'b0010, 15'h000, 15'h000};
  localparam result_t HighPins  = {4'b1100, 15'h000, 15'h000};
  localparam result_t LatchOnes = {4'b1001, 15'h3FF, 15'h2AA};
  localparam result_t PrepOnes  = {4'b1000, 15'h3FF, 15'h2AA};
  localparam result_t Untyped   = '0;

  // One full frame at the reset bit count: ones on every clock high sample,
  // zeros in the clock low phases where the input must be ignored.
  dir_row_t directed_rows [25] = '{
    '{1'b1, 1'b1, PrepIdle},  '{1'b1, 1'b1, LoadPins},  '{1'b1, 1'b1, HighPins},
    '{1'b0, 1'b0, Untyped},   '{1'b1, 1'b0, Untyped},   '{1'b0, 1'b0, Untyped},
    '{1'b1, 1'b0, Untyped},   '{1'b0, 1'b0, Untyped},   '{1'b1, 1'b0, Untyped},
    '{1'b0, 1'b0, Untyped},   '{1'b1, 1'b0, Untyped},   '{1'b0, 1'b0, Untyped},
    '{1'b1, 1'b0, Untyped},   '{1'b0, 1'b0, Untyped},   '{1'b1, 1'b0, Untyped},
    '{1'b0, 1'b0, Untyped},   '{1'b1, 1'b0, Untyped},   '{1'b0, 1'b0, Untyped},
    '{1'b1, 1'b0, Untyped},   '{1'b0, 1'b0, Untyped},   '{1'b1, 1'b0, Untyped},
    '{1'b0, 1'b0, Untyped},   '{1'b1, 1'b0, Untyped},   '{1'b0, 1'b1, LatchOnes},
    '{1'b1, 1'b1, PrepOnes}
  };

  int bit_count_steps [10] = '{15, 0, 1, 10, 15, 3, 0, 7, 12, 1};

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CountWidth-1:0] cfg_data;

  srer_in_if  in_ch ();
  srer_out_if out_ch ();

  shift_register_encoder_reader_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predicted sequencer state, starting from its reset values.
  phase_t                seq_phase = PH_PREPARE;
  logic [CountWidth-1:0] bits_taken = '0;
  logic [AccWidth-1:0]   shift_acc = '0;
  logic [WordWidth-1:0]  latched_gray = '0;
  logic [CountWidth-1:0] frame_bits = BitCountReset;

  result_t pending_results [$];
  int      fail_count = 0;
  int      ticks_accepted = 0;
  int      burst_left = 0;
  int      cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("shift_register_encoder_reader_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [WordWidth-1:0] decode_gray(
    input logic [WordWidth-1:0]  g,
    input logic [CountWidth-1:0] n
  );
    logic [WordWidth-1:0] b;
    logic                 run;
    b = '0;
    run = 1'b0;
    for (int i = WordWidth - 1; i >= 0; i--) begin
      if (i < n) begin
        run = run ^ g[i];
        b[i] = run;
      end
    end
    return b;
  endfunction

  function automatic result_t sequencer_tick(input logic sbit);
    result_t r;
    r = '0;
    r.shift_load_n = 1'b1;
    case (seq_phase)
      PH_LOAD: begin
        r.shift_load_n = 1'b0;
        r.clock_inhibit = 1'b1;
        seq_phase = PH_HIGH;
      end
      PH_HIGH: begin
        r.serial_clock = 1'b1;
        shift_acc = shift_acc + (AccWidth'(sbit) << bits_taken);
        // The frame ends once the sample index has reached the current bit count.
        if (bits_taken >= frame_bits) begin
          seq_phase = PH_LATCH;
        end else begin
          bits_taken = bits_taken + 1'b1;
          seq_phase = PH_LOW;
        end
      end
      PH_LOW: begin
        seq_phase = PH_HIGH;
      end
      PH_LATCH: begin
        // The first sample duplicates bit zero and is dropped.
        latched_gray = shift_acc[AccWidth-1:1];
        r.word_valid = 1'b1;
        seq_phase = PH_PREPARE;
      end
      default: begin
        bits_taken = '0;
        shift_acc = '0;
        seq_phase = PH_LOAD;
      end
    endcase
    r.gray_word = latched_gray;
    r.binary_word = decode_gray(latched_gray, frame_bits);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [WordWidth-1:0] want,
                             input logic [WordWidth-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Offers one tick, waits for its transfer and records the expected result.
  task automatic send_tick(input logic sbit, input bit typed, input result_t want);
    int      gap;
    result_t predicted;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.serial_in <= sbit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = sequencer_tick(sbit);
    pending_results.push_back(typed ? want : predicted);
    ticks_accepted++;
    burst_left--;
  endtask

  task automatic write_bit_count(input logic [CountWidth-1:0] value);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    frame_bits = value;
  endtask

  // Receiver: switches between always ready, a fixed one-in-four stall and
  // random stalls, and twice holds off long enough to back up the input.
  initial begin
    int    mode;
    int    mode_left;
    int    hold_left;
    int    hold_index;
    int    pattern_count;
    int    hold_points [2];
    hold_points = '{300, 1000};
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_index = 0;
    pattern_count = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      pattern_count++;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_index < 2 && ticks_accepted >= hold_points[hold_index]) begin
        out_ch.ready <= 1'b0;
        hold_left = 90;
        hold_index++;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= (pattern_count % 4 != 0);
          default: out_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got %0h %0h %0h %0h %0h %0h",
                 $time, out_ch.shift_load_n, out_ch.serial_clock, out_ch.clock_inhibit,
                 out_ch.word_valid, out_ch.gray_word, out_ch.binary_word);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("shift_load_n", WordWidth'(want.shift_load_n),
                    WordWidth'(out_ch.shift_load_n));
        check_field("serial_clock", WordWidth'(want.serial_clock),
                    WordWidth'(out_ch.serial_clock));
        check_field("clock_inhibit", WordWidth'(want.clock_inhibit),
                    WordWidth'(out_ch.clock_inhibit));
        check_field("word_valid", WordWidth'(want.word_valid),
                    WordWidth'(out_ch.word_valid));
        check_field("gray_word", want.gray_word, out_ch.gray_word);
        check_field("binary_word", want.binary_word, out_ch.binary_word);
      end
    end
  end

  initial begin
    int   style;
    logic sbit;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.serial_in <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_tick(directed_rows[i].serial, directed_rows[i].typed, directed_rows[i].want);
    end

    // Fixed steps cover the extremes; two more bit counts are drawn at random.
    for (int step = 0; step < 12; step++) begin
      if (step < 10) begin
        write_bit_count(CountWidth'(bit_count_steps[step]));
      end else begin
        write_bit_count(CountWidth'($urandom_range(0, 15)));
      end
      style = 0;
      for (int k = 0; k < ItemsPerStep; k++) begin
        if (k % 30 == 0) begin
          style = $urandom_range(0, 5);
        end
        case (style)
          3:       sbit = 1'b1;
          4:       sbit = 1'b0;
          5:       sbit = k[0];
          default: sbit = 1'($urandom_range(0, 1));
        endcase
        send_tick(sbit, 1'b0, Untyped);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("shift_register_encoder_reader_unit regression: pass");
    end else begin
      $display("shift_register_encoder_reader_unit regression: fail");
    end
    $finish;
  end

endmodule
